// ===== hdl/rar_pkg.sv =====
// types and constants shared by the rational arithmetic reduction core
// depends on nothing; imported by rar_control, rar_datapath and the top level
`timescale 1ns / 1ps
package rar_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_ZERO    = 2'd0,
      ST_UNDEF   = 2'd1,
      ST_ONE     = 2'd2,
      ST_GENERAL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_GCD_INIT,
      UOP_GCD_STEP,
      UOP_GCD_STORE,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_DIV_STORE,
      UOP_MUL,
      UOP_COMBINE,
      UOP_EMIT
   } uop_type;

   // operand selectors for the gcd unit, the divider and the multiplier
   typedef enum logic [3:0] {
      SEL_NONE,
      SEL_DEN,
      SEL_MAG,
      SEL_MA,
      SEL_MB,
      SEL_P,
      SEL_Q,
      SEL_L,
      SEL_SA,
      SEL_SB,
      SEL_PM,
      SEL_QM
   } sel_type;

   typedef struct packed {
      uop_type uop;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic add_sub;
      logic p_zero;
      logic q_zero;
      logic gcd_done;
      logic div_last;
      logic out_busy;
   } sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ROUTE,
      S_GCD1_INIT,
      S_GCD1,
      S_DIV_INIT,
      S_DIV,
      S_DIV_ST,
      S_MUL_L,
      S_MUL_SA,
      S_MUL_SB,
      S_COMBINE,
      S_MUL_P,
      S_MUL_Q,
      S_CHECK,
      S_GCD2_INIT,
      S_GCD2,
      S_EMIT
   } state_type;

endpackage

// ===== hdl/rational_arith_reduce_core.sv =====
// rational arithmetic with gcd reduction: top level, stream ports and packing
// depends on rar_pkg, rar_control and rar_datapath
`timescale 1ns / 1ps
// usage
// - req channel carries one operation on two fractions; rsp channel returns one
//   reduced, classed result per request transfer, in order
// - one request at a time: req_tready is high only while the sequencer is idle
// - work per request, with W = 2*OPERAND_BITS:
//   zero denominator: straight to the result register
//   multiply / divide: two products, a gcd run and two divider passes; a zero
//   result or zero result denominator skips the gcd and the divider
//   add / subtract: a denominator gcd run, two divider passes, three products
//   and a combine, then a gcd run and two divider passes on the result
//   gcd runs are binary gcd; the W-bit serial divider and gcd unit set the rate
// - reset clears the sequencer and the result valid flag; no clearing pass
// - a stalled receiver holds the result in the output register; the next
//   request is taken and worked on meanwhile, and waits before its own result
//   until the earlier transfer completes
module rational_arith_reduce_core #(
   parameter int OPERAND_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // op, a_num, a_den, b_num, b_den from the lowest bit up, zero padded to bytes
   input  logic [((4*OPERAND_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // res_num, res_den, status, equal_flag from the lowest bit up, zero padded
   output logic [71:0]          rsp_tdata
);
   import rar_pkg::*;

   localparam int N = OPERAND_BITS;

   cmd_type            cmd;
   sts_type            sts;
   logic signed [31:0] res_num, res_den;
   logic [1:0]         res_status;
   logic               res_equal;

   // request field unpacking
   logic [1:0]          op;
   logic signed [N-1:0] a_num, b_num;
   logic [N-2:0]        a_den, b_den;

   assign op    = req_tdata[1:0];
   assign a_num = req_tdata[N+1:2];
   assign a_den = req_tdata[2*N:N+2];
   assign b_num = req_tdata[3*N:2*N+1];
   assign b_den = req_tdata[4*N-1:3*N+1];

   rar_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rar_datapath #(
      .N (N)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_op      (op),
      .in_a_num   (a_num),
      .in_a_den   (a_den),
      .in_b_num   (b_num),
      .in_b_den   (b_den),
      .cmd        (cmd),
      .sts        (sts),
      .res_num    (res_num),
      .res_den    (res_den),
      .res_status (res_status),
      .res_equal  (res_equal),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready)
   );

   assign rsp_tdata = {5'b0, res_equal, res_status, res_den, res_num};

endmodule

// ===== hdl/rar_control.sv =====
// sequencing state machine for the rational arithmetic reduction core
// depends on rar_pkg; drives rar_datapath through command and status structs
`timescale 1ns / 1ps
module rar_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output rar_pkg::cmd_type cmd,
   input  rar_pkg::sts_type sts
);
   import rar_pkg::*;

   state_type state_ff, state_in;
   sel_type   dsel_ff, dsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dsel_ff  <= SEL_MA;
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dsel_in   = dsel_ff;
      cmd.uop   = UOP_NONE;
      cmd.sel   = SEL_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.uop  = UOP_LOAD;
               state_in = S_ROUTE;
            end
         end
         S_ROUTE: begin
            if (sts.den_zero) state_in = S_EMIT;
            else if (sts.add_sub) state_in = S_GCD1_INIT;
            else state_in = S_MUL_P;
         end
         S_GCD1_INIT: begin
            cmd.uop  = UOP_GCD_INIT;
            cmd.sel  = SEL_DEN;
            state_in = S_GCD1;
         end
         S_GCD1: begin
            if (sts.gcd_done) begin
               cmd.uop  = UOP_GCD_STORE;
               dsel_in  = SEL_MA;
               state_in = S_DIV_INIT;
            end else begin
               cmd.uop = UOP_GCD_STEP;
            end
         end
         S_DIV_INIT: begin
            cmd.uop  = UOP_DIV_INIT;
            cmd.sel  = dsel_ff;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.uop = UOP_DIV_STEP;
            if (sts.div_last) state_in = S_DIV_ST;
         end
         S_DIV_ST: begin
            cmd.uop = UOP_DIV_STORE;
            cmd.sel = dsel_ff;
            case (dsel_ff)
               SEL_MA: begin
                  dsel_in  = SEL_MB;
                  state_in = S_DIV_INIT;
               end
               SEL_MB: state_in = S_MUL_L;
               SEL_P: begin
                  dsel_in  = SEL_Q;
                  state_in = S_DIV_INIT;
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_MUL_L: begin
            cmd.uop  = UOP_MUL;
            cmd.sel  = SEL_L;
            state_in = S_MUL_SA;
         end
         S_MUL_SA: begin
            cmd.uop  = UOP_MUL;
            cmd.sel  = SEL_SA;
            state_in = S_MUL_SB;
         end
         S_MUL_SB: begin
            cmd.uop  = UOP_MUL;
            cmd.sel  = SEL_SB;
            state_in = S_COMBINE;
         end
         S_COMBINE: begin
            cmd.uop  = UOP_COMBINE;
            state_in = S_CHECK;
         end
         S_MUL_P: begin
            cmd.uop  = UOP_MUL;
            cmd.sel  = SEL_PM;
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            cmd.uop  = UOP_MUL;
            cmd.sel  = SEL_QM;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.p_zero || sts.q_zero) state_in = S_EMIT;
            else state_in = S_GCD2_INIT;
         end
         S_GCD2_INIT: begin
            cmd.uop  = UOP_GCD_INIT;
            cmd.sel  = SEL_MAG;
            state_in = S_GCD2;
         end
         S_GCD2: begin
            if (sts.gcd_done) begin
               cmd.uop  = UOP_GCD_STORE;
               dsel_in  = SEL_P;
               state_in = S_DIV_INIT;
            end else begin
               cmd.uop = UOP_GCD_STEP;
            end
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.uop  = UOP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hdl/rar_datapath.sv =====
// datapath: operand registers, shared multiplier, binary gcd unit, serial divider
// and result register; depends on rar_pkg, commanded by rar_control
`timescale 1ns / 1ps
module rar_datapath #(
   parameter int N = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          in_op,
   input  logic signed [N-1:0] in_a_num,
   input  logic [N-2:0]        in_a_den,
   input  logic signed [N-1:0] in_b_num,
   input  logic [N-2:0]        in_b_den,
   input  rar_pkg::cmd_type    cmd,
   output rar_pkg::sts_type    sts,
   output logic signed [31:0]  res_num,
   output logic signed [31:0]  res_den,
   output logic [1:0]          res_status,
   output logic                res_equal,
   output logic                res_valid,
   input  logic                res_ready
);
   import rar_pkg::*;

   localparam int W  = 2 * N;
   localparam int CW = $clog2(W);
   localparam int KW = $clog2(W + 1);

   op_type             op_ff, op_in;
   logic signed [N-1:0] an_ff, an_in, bn_ff, bn_in, ad_ff, ad_in, bd_ff, bd_in;
   logic signed [N-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic               den_zero_ff, den_zero_in;
   logic signed [W-1:0] sa_ff, sa_in, sb_ff, sb_in, p_ff, p_in, q_ff, q_in;
   logic [W-1:0]       g_ff, g_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [KW-1:0]      gk_ff, gk_in;
   logic [W-1:0]       dq_ff, dq_in, rem_ff, rem_in;
   logic [CW-1:0]      dcnt_ff, dcnt_in;
   logic signed [31:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [1:0]         rs_ff, rs_in;
   logic               re_ff, re_in, rv_ff, rv_in;

   logic [W-1:0]        p_mag, q_mag, dividend;
   logic signed [N-1:0] mx, my;
   logic signed [W-1:0] mxe, mye, prod, quo_s;
   logic [W:0]          shifted, diff;
   logic signed [W+31:0] pe, qe;

   assign p_mag = p_ff[W-1] ? W'(-p_ff) : W'(p_ff);
   assign q_mag = q_ff[W-1] ? W'(-q_ff) : W'(q_ff);
   assign pe    = {{32{p_ff[W-1]}}, p_ff};
   assign qe    = {{32{q_ff[W-1]}}, q_ff};

   // multiplier operand selection
   always_comb begin
      mx = an_ff;
      my = bn_ff;
      case (cmd.sel)
         SEL_L: begin
            mx = mb_ff;
            my = bd_ff;
         end
         SEL_SA: begin
            mx = ma_ff;
            my = an_ff;
         end
         SEL_SB: begin
            mx = mb_ff;
            my = bn_ff;
         end
         SEL_PM: begin
            mx = an_ff;
            my = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         SEL_QM: begin
            mx = ad_ff;
            my = (op_ff == OP_MUL) ? bd_ff : bn_ff;
         end
         default: ;
      endcase
   end

   assign mxe  = {{N{mx[N-1]}}, mx};
   assign mye  = {{N{my[N-1]}}, my};
   assign prod = mxe * mye;

   always_comb begin
      case (cmd.sel)
         SEL_MA:  dividend = {{N{1'b0}}, bd_ff};
         SEL_MB:  dividend = {{N{1'b0}}, ad_ff};
         SEL_P:   dividend = p_mag;
         default: dividend = q_mag;
      endcase
   end

   assign shifted = {rem_ff, dq_ff[W-1]};
   assign diff    = shifted - {1'b0, g_ff};
   assign quo_s   = dq_ff;

   always_comb begin
      op_in       = op_ff;
      an_in       = an_ff;
      bn_in       = bn_ff;
      ad_in       = ad_ff;
      bd_in       = bd_ff;
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      den_zero_in = den_zero_ff;
      sa_in       = sa_ff;
      sb_in       = sb_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      g_in        = g_ff;
      gx_in       = gx_ff;
      gy_in       = gy_ff;
      gk_in       = gk_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      rn_in       = rn_ff;
      rd_in       = rd_ff;
      rs_in       = rs_ff;
      re_in       = re_ff;
      rv_in       = rv_ff && !res_ready;
      unique case (cmd.uop)
         UOP_LOAD: begin
            op_in       = op_type'(in_op);
            an_in       = in_a_num;
            bn_in       = in_b_num;
            ad_in       = {1'b0, in_a_den};
            bd_in       = {1'b0, in_b_den};
            den_zero_in = (in_a_den == '0) || (in_b_den == '0);
         end
         UOP_GCD_INIT: begin
            gk_in = '0;
            if (cmd.sel == SEL_DEN) begin
               gx_in = {{N{1'b0}}, ad_ff};
               gy_in = {{N{1'b0}}, bd_ff};
            end else begin
               gx_in = p_mag;
               gy_in = q_mag;
            end
         end
         UOP_GCD_STEP: begin
            if (gx_ff != '0) begin
               if (!gx_ff[0] && !gy_ff[0]) begin
                  gx_in = gx_ff >> 1;
                  gy_in = gy_ff >> 1;
                  gk_in = gk_ff + 1'b1;
               end else if (!gx_ff[0]) begin
                  gx_in = gx_ff >> 1;
               end else if (!gy_ff[0]) begin
                  gy_in = gy_ff >> 1;
               end else if (gx_ff >= gy_ff) begin
                  gx_in = (gx_ff - gy_ff) >> 1;
               end else begin
                  gy_in = (gy_ff - gx_ff) >> 1;
               end
            end
         end
         UOP_GCD_STORE: g_in = gy_ff << gk_ff;
         UOP_DIV_INIT: begin
            dq_in   = dividend;
            rem_in  = '0;
            dcnt_in = '0;
         end
         UOP_DIV_STEP: begin
            dcnt_in = dcnt_ff + 1'b1;
            if (!diff[W]) begin
               rem_in = diff[W-1:0];
               dq_in  = {dq_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               dq_in  = {dq_ff[W-2:0], 1'b0};
            end
         end
         UOP_DIV_STORE: begin
            case (cmd.sel)
               SEL_MA:  ma_in = quo_s[N-1:0];
               SEL_MB:  mb_in = quo_s[N-1:0];
               SEL_P:   p_in  = p_ff[W-1] ? -quo_s : quo_s;
               default: q_in  = q_ff[W-1] ? -quo_s : quo_s;
            endcase
         end
         UOP_MUL: begin
            case (cmd.sel)
               SEL_SA:  sa_in = prod;
               SEL_SB:  sb_in = prod;
               SEL_PM:  p_in  = prod;
               default: q_in  = prod;
            endcase
         end
         UOP_COMBINE: p_in = (op_ff == OP_ADD) ? sa_ff + sb_ff : sa_ff - sb_ff;
         UOP_EMIT: begin
            rv_in = 1'b1;
            re_in = 1'b0;
            if (den_zero_ff) begin
               rn_in = '0;
               rd_in = '0;
               rs_in = ST_UNDEF;
            end else if (p_ff == '0) begin
               rn_in = '0;
               rd_in = 32'sd1;
               rs_in = ST_ZERO;
               re_in = (op_ff == OP_SUB);
            end else if (q_ff == '0) begin
               rn_in = '0;
               rd_in = '0;
               rs_in = ST_UNDEF;
            end else begin
               rn_in = pe[31:0];
               rd_in = qe[31:0];
               rs_in = (p_ff == W'(1) && q_ff == W'(1)) ? ST_ONE : ST_GENERAL;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      an_ff       <= an_in;
      bn_ff       <= bn_in;
      ad_ff       <= ad_in;
      bd_ff       <= bd_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      den_zero_ff <= den_zero_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      g_ff        <= g_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gk_ff       <= gk_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      rs_ff       <= rs_in;
      re_ff       <= re_in;
   end

   assign sts.den_zero = den_zero_ff;
   assign sts.add_sub  = (op_ff == OP_ADD) || (op_ff == OP_SUB);
   assign sts.p_zero   = (p_ff == '0);
   assign sts.q_zero   = (q_ff == '0);
   assign sts.gcd_done = (gx_ff == '0);
   assign sts.div_last = (dcnt_ff == CW'(W - 1));
   assign sts.out_busy = rv_ff && !res_ready;

   assign res_num    = rn_ff;
   assign res_den    = rd_ff;
   assign res_status = rs_ff;
   assign res_equal  = re_ff;
   assign res_valid  = rv_ff;

endmodule

// ===== sim/rational_arith_reduce_core_tb.sv =====
// self-checking testbench for rational_arith_reduce_core: directed table then random traffic
// depends on rar_pkg and the rational_arith_reduce_core rtl
`timescale 1ns / 1ps
module rational_arith_reduce_core_tb;
   import rar_pkg::*;

   typedef struct {
      op_type            op;
      logic signed [15:0] a_num;
      logic [14:0]       a_den;
      logic signed [15:0] b_num;
      logic [14:0]       b_den;
   } frac_pair_type;

   typedef struct {
      logic [31:0] num;
      logic [31:0] den;
      status_type  status;
      logic        equal;
   } reduced_type;

   typedef struct {
      frac_pair_type pair;
      bit            typed;
      reduced_type   res;
   } table_row_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_ROWS = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // op, a_num, a_den, b_num, b_den
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // res_num, res_den, status, equal_flag

   reduced_type expected_results[$];
   int          mismatches = 0;
   int          stall_pct = 0;
   int          idle_cycles = 0;

   rational_arith_reduce_core #(.OPERAND_BITS(16)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic longint unsigned abs_val(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // rational arithmetic followed by reduction to lowest terms
   function automatic reduced_type reduce_fraction(frac_pair_type f);
      reduced_type r;
      longint an, ad, bn, bd, p, q, lcm;
      longint unsigned g;
      an = longint'(f.a_num);
      ad = longint'(f.a_den);
      bn = longint'(f.b_num);
      bd = longint'(f.b_den);
      r = '{num: 32'd0, den: 32'd0, status: ST_UNDEF, equal: 1'b0};
      if (ad == 0 || bd == 0)
         return r;
      if (f.op == OP_ADD || f.op == OP_SUB) begin
         lcm = (ad / longint'(gcd_mag(ad, bd))) * bd;
         p = (f.op == OP_ADD) ? (lcm / ad) * an + (lcm / bd) * bn
                              : (lcm / ad) * an - (lcm / bd) * bn;
         q = lcm;
         r.equal = (f.op == OP_SUB) && (p == 0);
      end else if (f.op == OP_MUL) begin
         p = an * bn;
         q = ad * bd;
      end else begin
         p = an * bd;
         q = ad * bn;
      end
      if (p == 0) begin
         r.den = 32'd1;
         r.status = ST_ZERO;
         return r;
      end
      if (q == 0)
         return r;
      g = gcd_mag(abs_val(p), abs_val(q));
      if (g > 1) begin
         p = p / longint'(g);
         q = q / longint'(g);
      end
      r.num = p[31:0];
      r.den = q[31:0];
      r.status = (p == 1 && q == 1) ? ST_ONE : ST_GENERAL;
      return r;
   endfunction

   // extremes, zero denominators, zero results, exactly one and equality
   table_row_type directed_rows[N_ROWS] = '{
      '{'{OP_ADD, 16'sd1, 15'd0, 16'sd1, 15'd1}, 1'b1, '{32'd0, 32'd0, ST_UNDEF, 1'b0}},
      '{'{OP_SUB, 16'sd1, 15'd1, 16'sd1, 15'd0}, 1'b1, '{32'd0, 32'd0, ST_UNDEF, 1'b0}},
      '{'{OP_MUL, 16'sd0, 15'd0, 16'sd0, 15'd0}, 1'b1, '{32'd0, 32'd0, ST_UNDEF, 1'b0}},
      '{'{OP_DIV, -16'sd5, 15'd0, 16'sd3, 15'd7}, 1'b1, '{32'd0, 32'd0, ST_UNDEF, 1'b0}},
      '{'{OP_SUB, 16'sd3, 15'd4, 16'sd3, 15'd4}, 1'b1, '{32'd0, 32'd1, ST_ZERO, 1'b1}},
      '{'{OP_MUL, 16'sd0, 15'd5, 16'sd7, 15'd3}, 1'b1, '{32'd0, 32'd1, ST_ZERO, 1'b0}},
      '{'{OP_DIV, 16'sd5, 15'd1, 16'sd0, 15'd3}, 1'b1, '{32'd0, 32'd0, ST_UNDEF, 1'b0}},
      '{'{OP_DIV, 16'sd0, 15'd2, 16'sd0, 15'd3}, 1'b1, '{32'd0, 32'd1, ST_ZERO, 1'b0}},
      '{'{OP_ADD, 16'sd1, 15'd2, 16'sd1, 15'd2}, 1'b1, '{32'd1, 32'd1, ST_ONE, 1'b0}},
      '{'{OP_MUL, -16'sd1, 15'd1, -16'sd1, 15'd1}, 1'b1, '{32'd1, 32'd1, ST_ONE, 1'b0}},
      '{'{OP_DIV, 16'sd1, 15'd1, -16'sd1, 15'd1}, 1'b1,
        '{32'd1, 32'hFFFFFFFF, ST_GENERAL, 1'b0}},
      '{'{OP_ADD, 16'sd0, 15'd3, 16'sd0, 15'd9}, 1'b1, '{32'd0, 32'd1, ST_ZERO, 1'b0}},
      '{'{OP_ADD, 16'h7FFF, 15'h7FFF, 16'h7FFF, 15'h7FFE}, 1'b0,
        '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_SUB, -16'sd32768, 15'h7FFF, 16'h7FFF, 15'h7FFE}, 1'b0,
        '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1}, 1'b0,
        '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_MUL, 16'h7FFF, 15'h7FFF, -16'sd32768, 15'h7FFF}, 1'b0,
        '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_DIV, -16'sd32768, 15'h7FFF, 16'h7FFF, 15'd1}, 1'b0,
        '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_DIV, 16'sd6, 15'd4, -16'sd9, 15'd2}, 1'b0, '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_SUB, -16'sd7, 15'd6, 16'sd5, 15'd10}, 1'b0, '{32'd0, 32'd0, ST_ZERO, 1'b0}},
      '{'{OP_ADD, 16'sd1, 15'd1, -16'sd2, 15'd1}, 1'b0, '{32'd0, 32'd0, ST_ZERO, 1'b0}}
   };

   // present one request and hold it until the transfer, with random idle gaps first
   task automatic send_pair(frac_pair_type f, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {f.b_den, f.b_num, f.a_den, f.a_num, f.op};
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly well-formed fractions, some small to hit one and equality, a few broken
   function automatic frac_pair_type random_pair();
      frac_pair_type f;
      int kind;
      kind = $urandom_range(99);
      f.op = op_type'($urandom_range(3));
      f.a_num = 16'($urandom); f.b_num = 16'($urandom);
      f.a_den = 15'($urandom); f.b_den = 15'($urandom);
      if (kind < 30) begin
         f.a_num = $signed(16'($urandom_range(12))) - 16'sd6;
         f.b_num = $signed(16'($urandom_range(12))) - 16'sd6;
         f.a_den = 15'($urandom_range(1, 12));
         f.b_den = 15'($urandom_range(1, 12));
         if ($urandom_range(3) == 0) begin
            f.b_num = f.a_num;
            f.b_den = f.a_den;
         end
      end else if (kind < 35) begin
         if ($urandom_range(1)) f.a_den = '0; else f.b_den = '0;
      end else if (kind < 40) begin
         f.a_den = $urandom_range(1) ? 15'h7FFF : 15'd1;
         f.b_den = $urandom_range(1) ? 15'h7FFF : 15'd1;
         f.a_num = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      end
      if (f.a_den == 0 && kind >= 35) f.a_den = 15'd1;
      if (f.b_den == 0 && kind >= 35) f.b_den = 15'd1;
      return f;
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checking and watchdog
   always @(posedge clock) begin
      reduced_type want, got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.num = rsp_tdata[31:0];
            got.den = rsp_tdata[63:32];
            got.status = status_type'(rsp_tdata[65:64]);
            got.equal = rsp_tdata[66];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: num %h den %h", got.num, got.den);
            end else begin
               want = expected_results.pop_front();
               if (got.num !== want.num || got.den !== want.den ||
                   got.status !== want.status || got.equal !== want.equal) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: want %h/%h st %0d eq %b, got %h/%h st %0d eq %b",
                              want.num, want.den, want.status, want.equal,
                              got.num, got.den, got.status, got.equal);
               end
            end
         end
      end
   end

   initial begin
      frac_pair_type f;
      int idle_pct;
      req_tvalid = 1'b0;
      req_tdata = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         expected_results.push_back(directed_rows[i].typed ? directed_rows[i].res
                                    : reduce_fraction(directed_rows[i].pair));
         send_pair(directed_rows[i].pair, 0);
      end

      // phases: free-running, idle sender, stalling receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 86 : 26) : 0;
         stall_pct <= (phase == 2) ? 86 : (phase == 3) ? 26 : 0;
         for (int n = 0; n < 400; n++) begin
            f = random_pair();
            expected_results.push_back(reduce_fraction(f));
            send_pair(f, (n % 100 < 15) ? 0 : idle_pct);
         end
         // drain completely before the next phase
         req_tvalid <= 1'b0;
         while (expected_results.size() != 0) @(posedge clock);
      end

      repeat (300) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
